// ===== rtl/core/quadratic_root_solver_unit_macros.svh =====
// Assertion helpers for the root solver.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define QRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/qrs_pkg.sv =====
`default_nettype none
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_W     = 16;
  localparam int PROD_W    = 2 * WORD_BITS;
  localparam int DISC_W    = 2 * WORD_BITS + 1;
  localparam int SQ_W      = WORD_BITS + 1;
  localparam int SQ_IN_W   = 2 * SQ_W;
  localparam int NUM_W     = WORD_BITS + 3;
  localparam int DEN_W     = WORD_BITS + 2;
  localparam int NMAG_W    = WORD_BITS + 2;
  localparam int DMAG_W    = WORD_BITS + 1;
  localparam int DVD_W     = NMAG_W + FRAC_BITS;
  localparam int FRONT_LAT = 4;
  localparam int DIV_LAT   = DVD_W + 1;
  localparam int TOTAL_LAT = FRONT_LAT + SQ_W + 1 + DIV_LAT + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [1:0] {
    CASE_DEGEN,
    CASE_LINEAR,
    CASE_C_ZERO,
    CASE_QUAD
  } case_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_ALL  = 2'd3
  } kind_t;

  typedef struct packed {
    case_t cse;
    logic  c_near;
    logic  neg_disc;
    logic  near_disc;
    word_t a;
    word_t b;
    word_t c;
  } sq_tag_t;

  typedef struct packed {
    kind_t kind;
    logic  en1;
    logic  en2;
  } post_tag_t;

  function automatic logic [WORD_BITS-1:0] mag(input word_t x);
    logic [WORD_BITS-1:0] u;
    u = x;
    return x[WORD_BITS-1] ? (~u + 1'b1) : u;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/qrs_front.sv =====
`default_nettype none
module qrs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  qrs_pkg::word_t                in_a,
  input  qrs_pkg::word_t                in_b,
  input  qrs_pkg::word_t                in_c,
  input  logic [qrs_pkg::TOL_W-1:0]     tol,
  output logic                          out_valid,
  output logic [qrs_pkg::DISC_W-1:0]    out_disc,
  output qrs_pkg::sq_tag_t              out_tag
);
  localparam int W      = qrs_pkg::WORD_BITS;
  localparam int F      = qrs_pkg::FRAC_BITS;
  localparam int PROD_W = qrs_pkg::PROD_W;
  localparam int DISC_W = qrs_pkg::DISC_W;

  logic [W-1:0]      tol_ext, ma_nxt, mb_nxt, mc_nxt, ma_r, mb_r, mc_r;
  logic              an, bn, cn, opp, borrow;
  qrs_pkg::sq_tag_t  tag1_nxt, tag1_r, tag2_r, tag3_nxt, tag3_r, tag4_nxt, tag4_r;
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [PROD_W-1:0] b2_r, ac_r;
  logic [DISC_W-1:0] ac4, b2e, sum, disc_nxt, disc3_r, disc4_r, tol_disc;
  logic [DISC_W:0]   diff;

  // classify on magnitudes
  always_comb begin
    tol_ext = W'(tol);
    ma_nxt  = qrs_pkg::mag(in_a);
    mb_nxt  = qrs_pkg::mag(in_b);
    mc_nxt  = qrs_pkg::mag(in_c);
    an      = ma_nxt < tol_ext;
    bn      = mb_nxt < tol_ext;
    cn      = mc_nxt < tol_ext;
    tag1_nxt        = '0;
    tag1_nxt.a      = in_a;
    tag1_nxt.b      = in_b;
    tag1_nxt.c      = in_c;
    tag1_nxt.c_near = cn;
    if (an) begin
      tag1_nxt.cse = bn ? qrs_pkg::CASE_DEGEN : qrs_pkg::CASE_LINEAR;
    end else begin
      tag1_nxt.cse = cn ? qrs_pkg::CASE_C_ZERO : qrs_pkg::CASE_QUAD;
    end
  end

  // discriminant from b^2 and 4ac
  always_comb begin
    ac4      = {ac_r[PROD_W-2:0], 2'b00};
    b2e      = {1'b0, b2_r};
    opp      = tag2_r.a[W-1] ^ tag2_r.c[W-1];
    sum      = b2e + ac4;
    diff     = {1'b0, b2e} - {1'b0, ac4};
    borrow   = diff[DISC_W];
    disc_nxt = opp ? sum : (borrow ? '0 : diff[DISC_W-1:0]);
    tag3_nxt = tag2_r;
    tag3_nxt.neg_disc = !opp && borrow;
  end

  always_comb begin
    tol_disc = DISC_W'(tol) << F;
    tag4_nxt = tag3_r;
    tag4_nxt.near_disc = disc3_r < tol_disc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ma_r    <= ma_nxt;
    mb_r    <= mb_nxt;
    mc_r    <= mc_nxt;
    tag1_r  <= tag1_nxt;
    b2_r    <= PROD_W'(mb_r) * PROD_W'(mb_r);
    ac_r    <= PROD_W'(ma_r) * PROD_W'(mc_r);
    tag2_r  <= tag1_r;
    disc3_r <= disc_nxt;
    tag3_r  <= tag3_nxt;
    disc4_r <= disc3_r;
    tag4_r  <= tag4_nxt;
  end

  assign out_valid = v4_r;
  assign out_disc  = disc4_r;
  assign out_tag   = tag4_r;

endmodule
`default_nettype wire

// ===== rtl/core/qrs_sqrt.sv =====
`default_nettype none
module qrs_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [qrs_pkg::DISC_W-1:0]  in_rad,
  input  qrs_pkg::sq_tag_t            in_tag,
  output logic                        out_valid,
  output logic [qrs_pkg::SQ_W-1:0]    out_root,
  output qrs_pkg::sq_tag_t            out_tag
);
  localparam int SQ_W    = qrs_pkg::SQ_W;
  localparam int SQ_IN_W = qrs_pkg::SQ_IN_W;
  localparam int RW      = SQ_W + 2;

  logic [RW-1:0]      rem_r  [1:SQ_W-1];
  logic [SQ_IN_W-1:0] x_r    [1:SQ_W-1];
  logic [SQ_W-1:0]    root_r [1:SQ_W];
  qrs_pkg::sq_tag_t   tag_r  [1:SQ_W];
  logic [1:SQ_W]      vld_r;

  // one result bit per stage, two radicand bits consumed
  for (genvar k = 0; k < SQ_W; k++) begin : g_stage
    logic [RW-1:0]      rem_p, rem_sh, trial, rem_nxt;
    logic [SQ_IN_W-1:0] x_p;
    logic [SQ_W-1:0]    root_p, root_nxt;
    qrs_pkg::sq_tag_t   tag_p;
    logic               v_p, ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign x_p    = SQ_IN_W'(in_rad);
      assign root_p = '0;
      assign tag_p  = in_tag;
      assign v_p    = in_valid;
    end else begin : g_rest
      assign rem_p  = rem_r[k];
      assign x_p    = x_r[k];
      assign root_p = root_r[k];
      assign tag_p  = tag_r[k];
      assign v_p    = vld_r[k];
    end

    always_comb begin
      rem_sh   = {rem_p[SQ_W-1:0], x_p[SQ_IN_W-1 -: 2]};
      trial    = {root_p, 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_p[SQ_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      root_r[k+1] <= root_nxt;
      tag_r[k+1]  <= tag_p;
    end

    if (k < SQ_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k+1] <= rem_nxt;
        x_r[k+1]   <= {x_p[SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld_r[SQ_W];
  assign out_root  = root_r[SQ_W];
  assign out_tag   = tag_r[SQ_W];

endmodule
`default_nettype wire

// ===== rtl/core/qrs_div.sv =====
`default_nettype none
module qrs_div (
  input  logic                              clk,
  input  logic signed [qrs_pkg::NUM_W-1:0]  in_num,
  input  logic signed [qrs_pkg::DEN_W-1:0]  in_den,
  output logic [qrs_pkg::DVD_W-1:0]         out_quo,
  output logic                              out_neg,
  output logic                              out_nz
);
  localparam int F      = qrs_pkg::FRAC_BITS;
  localparam int NUM_W  = qrs_pkg::NUM_W;
  localparam int DEN_W  = qrs_pkg::DEN_W;
  localparam int NMAG_W = qrs_pkg::NMAG_W;
  localparam int DMAG_W = qrs_pkg::DMAG_W;
  localparam int DVD_W  = qrs_pkg::DVD_W;

  logic [NUM_W-1:0]  nabs;
  logic [DEN_W-1:0]  dabs;
  logic [DVD_W-1:0]  sh_r  [0:DVD_W-1];
  logic [DMAG_W-1:0] d_r   [0:DVD_W-1];
  logic [DMAG_W:0]   rem_r [1:DVD_W-1];
  logic [DVD_W-1:0]  q_r   [1:DVD_W];
  logic [0:DVD_W]    neg_r, nz_r;

  // take magnitudes, scale the numerator by the fraction bits
  always_comb begin
    nabs = in_num[NUM_W-1] ? -in_num : in_num;
    dabs = in_den[DEN_W-1] ? -in_den : in_den;
  end

  always_ff @(posedge clk) begin
    sh_r[0]  <= {nabs[NMAG_W-1:0], {F{1'b0}}};
    d_r[0]   <= dabs[DMAG_W-1:0];
    neg_r[0] <= in_num[NUM_W-1] ^ in_den[DEN_W-1];
    nz_r[0]  <= |in_num;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic [DMAG_W:0]  rem_p, rem_sh, rem_nxt;
    logic [DVD_W-1:0] q_p;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign q_p   = '0;
    end else begin : g_rest
      assign rem_p = rem_r[k];
      assign q_p   = q_r[k];
    end

    always_comb begin
      rem_sh  = {rem_p[DMAG_W-1:0], sh_r[k][DVD_W-1]};
      ge      = rem_sh >= {1'b0, d_r[k]};
      rem_nxt = ge ? (rem_sh - {1'b0, d_r[k]}) : rem_sh;
    end

    always_ff @(posedge clk) begin
      q_r[k+1]   <= {q_p[DVD_W-2:0], ge};
      neg_r[k+1] <= neg_r[k];
      nz_r[k+1]  <= nz_r[k];
    end

    if (k < DVD_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[k+1] <= rem_nxt;
        sh_r[k+1]  <= {sh_r[k][DVD_W-2:0], 1'b0};
        d_r[k+1]   <= d_r[k];
      end
    end
  end

  assign out_quo = q_r[DVD_W];
  assign out_neg = neg_r[DVD_W];
  assign out_nz  = nz_r[DVD_W];

endmodule
`default_nettype wire

// ===== rtl/core/quadratic_root_solver_unit.sv =====
`default_nettype none
// Quadratic root solver for a*x^2 + b*x + c = 0 on signed Q16.16 coefficients.
// Pulse start with the three coefficients; busy is never raised, so a new word
// is taken on every cycle. Each word yields exactly one result word, shown for
// one cycle with out_strobe once it has passed the pipeline stages (4 front stages
// for classification, the two 32x32 products and the discriminant; 33 square
// root stages, one per root bit; one setup stage; 51 divider stages, one per
// quotient bit of the 50-bit scaled dividend plus its input stage; one output
// stage). Results leave in the order the words came in. The receiver cannot
// stall the block: it must take every strobed word. Both roots are divided in
// parallel lanes. Coefficients whose magnitude is below zero_tolerance count
// as zero; write the tolerance through cfg_we/cfg_wdata only while no word is
// in flight. Roots out of range saturate and raise out_root_saturated.
`include "quadratic_root_solver_unit_macros.svh"
module quadratic_root_solver_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [qrs_pkg::WORD_BITS-1:0]  in_coef_a,
  input  logic signed [qrs_pkg::WORD_BITS-1:0]  in_coef_b,
  input  logic signed [qrs_pkg::WORD_BITS-1:0]  in_coef_c,
  input  logic                                  cfg_we,
  input  logic [qrs_pkg::TOL_W-1:0]             cfg_wdata,
  output logic                                  out_strobe,
  output logic [1:0]                            out_solution_kind,
  output logic signed [qrs_pkg::WORD_BITS-1:0]  out_root_first,
  output logic signed [qrs_pkg::WORD_BITS-1:0]  out_root_second,
  output logic                                  out_root_saturated
);
  localparam int W       = qrs_pkg::WORD_BITS;
  localparam int SQ_W    = qrs_pkg::SQ_W;
  localparam int NUM_W   = qrs_pkg::NUM_W;
  localparam int DEN_W   = qrs_pkg::DEN_W;
  localparam int DVD_W   = qrs_pkg::DVD_W;
  localparam int DIV_LAT = qrs_pkg::DIV_LAT;
  localparam int DISC_W  = qrs_pkg::DISC_W;

  // Fold one divider lane: clip to the word range, apply the sign, zero
  // unused lanes and zero numerators.
  function automatic logic [W:0] fold(input logic en, input logic nz, input logic neg,
                                      input logic [DVD_W-1:0] q);
    logic [DVD_W-1:0] lim;
    logic [W-1:0]     m;
    logic             sat;
    lim = neg ? (DVD_W'(1) << (W - 1)) : ((DVD_W'(1) << (W - 1)) - 1'b1);
    sat = en && nz && (q > lim);
    m   = sat ? lim[W-1:0] : q[W-1:0];
    if (!(en && nz)) begin
      m = '0;
    end
    return {sat, (neg ? (~m + 1'b1) : m)};
  endfunction

  logic [qrs_pkg::TOL_W-1:0] tol_r;
  logic                      accept;

  logic                      fr_v;
  logic [DISC_W-1:0]         fr_disc;
  qrs_pkg::sq_tag_t          fr_tag;

  logic                      sq_v;
  logic [SQ_W-1:0]           sq_root;
  qrs_pkg::sq_tag_t          sq_tag;

  logic signed [NUM_W-1:0]   b_n, c_n, s_n;
  logic signed [DEN_W-1:0]   a_d, b_d, a2_d;
  logic signed [NUM_W-1:0]   num1_nxt, num2_nxt, num1_r, num2_r;
  logic signed [DEN_W-1:0]   den1_nxt, den2_nxt, den1_r, den2_r;
  qrs_pkg::post_tag_t        ptag_nxt, ptag_r;
  logic                      su_v_r;

  logic [DVD_W-1:0]          q1, q2;
  logic                      neg1, neg2, nz1, nz2;

  logic [1:DIV_LAT]          pv_r;
  qrs_pkg::post_tag_t        pd_r [1:DIV_LAT];
  qrs_pkg::post_tag_t        pt;
  logic [W:0]                lane1, lane2;

  logic                      out_strobe_r;
  qrs_pkg::kind_t            kind_r;
  logic [W-1:0]              r1_r, r2_r;
  logic                      sat_r;

  // take a word every cycle; nothing downstream can push back
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= qrs_pkg::TOL_W'(1);
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  qrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_a      (in_coef_a),
    .in_b      (in_coef_b),
    .in_c      (in_coef_c),
    .tol       (tol_r),
    .out_valid (fr_v),
    .out_disc  (fr_disc),
    .out_tag   (fr_tag)
  );

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_v),
    .in_rad    (fr_disc),
    .in_tag    (fr_tag),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // Set up both divider lanes from the case found up front.
  always_comb begin
    b_n  = {{(NUM_W-W){sq_tag.b[W-1]}}, sq_tag.b};
    c_n  = {{(NUM_W-W){sq_tag.c[W-1]}}, sq_tag.c};
    s_n  = {{(NUM_W-SQ_W){1'b0}}, sq_root};
    a_d  = {{(DEN_W-W){sq_tag.a[W-1]}}, sq_tag.a};
    b_d  = {{(DEN_W-W){sq_tag.b[W-1]}}, sq_tag.b};
    a2_d = {{(DEN_W-W-1){sq_tag.a[W-1]}}, sq_tag.a, 1'b0};
    ptag_nxt = '0;
    num1_nxt = '0;
    den1_nxt = '0;
    num2_nxt = '0;
    den2_nxt = '0;
    case (sq_tag.cse)
      qrs_pkg::CASE_DEGEN: begin
        ptag_nxt.kind = sq_tag.c_near ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
      end
      qrs_pkg::CASE_LINEAR: begin
        // single root -c/b
        ptag_nxt.kind = qrs_pkg::KIND_ONE;
        ptag_nxt.en1  = 1'b1;
        num1_nxt      = -c_n;
        den1_nxt      = b_d;
      end
      qrs_pkg::CASE_C_ZERO: begin
        // roots 0 and -b/a
        ptag_nxt.kind = qrs_pkg::KIND_TWO;
        ptag_nxt.en2  = 1'b1;
        num2_nxt      = -b_n;
        den2_nxt      = a_d;
      end
      qrs_pkg::CASE_QUAD: begin
        if (!sq_tag.neg_disc) begin
          ptag_nxt.kind = qrs_pkg::KIND_TWO;
          ptag_nxt.en1  = 1'b1;
          ptag_nxt.en2  = 1'b1;
          den1_nxt      = a2_d;
          den2_nxt      = a2_d;
          if (sq_tag.near_disc) begin
            // double root -b/2a
            num1_nxt = -b_n;
            num2_nxt = -b_n;
          end else begin
            num1_nxt = s_n - b_n;
            num2_nxt = -b_n - s_n;
          end
        end
      end
      default: begin
        ptag_nxt.kind = qrs_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      su_v_r <= 1'b0;
    end else begin
      su_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    num1_r <= num1_nxt;
    den1_r <= den1_nxt;
    num2_r <= num2_nxt;
    den2_r <= den2_nxt;
    ptag_r <= ptag_nxt;
  end

  qrs_div u_div1 (
    .clk     (clk),
    .in_num  (num1_r),
    .in_den  (den1_r),
    .out_quo (q1),
    .out_neg (neg1),
    .out_nz  (nz1)
  );

  qrs_div u_div2 (
    .clk     (clk),
    .in_num  (num2_r),
    .in_den  (den2_r),
    .out_quo (q2),
    .out_neg (neg2),
    .out_nz  (nz2)
  );

  // Advance the valid bit and kind alongside the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else begin
      pv_r <= {su_v_r, pv_r[1:DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    pd_r[1] <= ptag_r;
    for (int i = 2; i <= DIV_LAT; i++) begin
      pd_r[i] <= pd_r[i-1];
    end
  end

  assign pt    = pd_r[DIV_LAT];
  assign lane1 = fold(pt.en1, nz1, neg1, q1);
  assign lane2 = fold(pt.en2, nz2, neg2, q2);

  // Output register: hold the word for exactly one strobe cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pv_r[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= pt.kind;
    r1_r   <= lane1[W-1:0];
    r2_r   <= lane2[W-1:0];
    sat_r  <= lane1[W] | lane2[W];
  end

  assign out_strobe         = out_strobe_r;
  assign out_solution_kind  = kind_r;
  assign out_root_first     = r1_r;
  assign out_root_second    = r2_r;
  assign out_root_saturated = sat_r;

  `QRS_ASSERT_IMP(a_strobe_follows_start, clk, rst_n, out_strobe, $past(start, qrs_pkg::TOTAL_LAT), "result word without a word taken at the pipeline latency")
  `QRS_ASSERT_IMP(a_sat_needs_root, clk, rst_n, out_strobe && out_root_saturated, out_solution_kind == qrs_pkg::KIND_ONE || out_solution_kind == qrs_pkg::KIND_TWO, "saturation flagged on a result without roots")
  `QRS_ASSERT_IMP(a_no_root_zero, clk, rst_n, out_strobe && (out_solution_kind == qrs_pkg::KIND_NONE || out_solution_kind == qrs_pkg::KIND_ALL), out_root_first == 0 && out_root_second == 0, "nonzero root on a rootless result")
  `QRS_ASSERT_NXT(a_all_x_clean, clk, rst_n, pv_r[DIV_LAT] && pt.kind == qrs_pkg::KIND_ALL, out_strobe && !out_root_saturated && out_root_first == 0, "every-x result not delivered clean")

endmodule
`default_nettype wire

// ===== sim/tb_quadratic_root_solver_unit.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_quadratic_root_solver_unit;

  // One expected result word, as the block reports it.
  typedef struct {
    qrs_pkg::kind_t kind;
    qrs_pkg::word_t root1;
    qrs_pkg::word_t root2;
    logic           sat;
  } roots_t;

  // One row of the directed table. When has_exp is clear the row is checked
  // against the predictor instead of the typed-in answer.
  typedef struct {
    qrs_pkg::word_t a;
    qrs_pkg::word_t b;
    qrs_pkg::word_t c;
    logic           has_exp;
    roots_t         exp;
  } coef_row_t;

  localparam int PHASE_ITEMS = 250;
  localparam int N_PHASES    = 5;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  qrs_pkg::word_t  in_coef_a;
  qrs_pkg::word_t  in_coef_b;
  qrs_pkg::word_t  in_coef_c;
  logic            cfg_we;
  logic [15:0]     cfg_wdata;
  logic            out_strobe;
  logic [1:0]      out_solution_kind;
  qrs_pkg::word_t  out_root_first;
  qrs_pkg::word_t  out_root_second;
  logic            out_root_saturated;

  // Predictor copy of the tolerance register.
  logic [15:0]  tol_model;
  roots_t       pending_roots[$];
  int           n_errors;
  int           n_words_in;
  int           n_words_out;
  int           n_sat_seen;
  int           n_kind_seen[4];

  quadratic_root_solver_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_coef_a          (in_coef_a),
    .in_coef_b          (in_coef_b),
    .in_coef_c          (in_coef_c),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .out_strobe         (out_strobe),
    .out_solution_kind  (out_solution_kind),
    .out_root_first     (out_root_first),
    .out_root_second    (out_root_second),
    .out_root_saturated (out_root_saturated)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [127:0] abs_wide(input longint x);
    return x < 0 ? 128'(-x) : 128'(x);
  endfunction

  function automatic logic near_zero(input longint x);
    return abs_wide(x) < 128'(tol_model);
  endfunction

  // Floor square root, one result bit per pass.
  function automatic longint floor_sqrt(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] bitv;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res[63:0]);
  endfunction

  // Fixed-point num/den, truncated toward zero, clipped to the word range.
  function automatic longint fx_divide(input longint num, input longint den,
                                       inout logic sat);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] limit;
    logic         neg;
    n   = abs_wide(num);
    d   = abs_wide(den);
    neg = (num < 0) != (den < 0);
    if (n == 0) return 0;
    limit = neg ? (128'd1 << (qrs_pkg::WORD_BITS - 1))
                : ((128'd1 << (qrs_pkg::WORD_BITS - 1)) - 1);
    if (d == 0) begin
      sat = 1'b1;
      q   = limit;
    end else begin
      q = (n << qrs_pkg::FRAC_BITS) / d;
      if (q > limit) begin
        sat = 1'b1;
        q   = limit;
      end
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic roots_t solve_roots(input qrs_pkg::word_t ca, input qrs_pkg::word_t cb,
                                         input qrs_pkg::word_t cc);
    longint       a;
    longint       b;
    longint       c;
    longint       r1;
    longint       r2;
    longint       s;
    logic         sat;
    logic [127:0] b2;
    logic [127:0] ac4;
    logic [127:0] disc;
    roots_t       res;
    a   = ca;
    b   = cb;
    c   = cc;
    r1  = 0;
    r2  = 0;
    sat = 1'b0;
    if (near_zero(a)) begin
      if (near_zero(b)) begin
        res.kind = near_zero(c) ? qrs_pkg::KIND_ALL : qrs_pkg::KIND_NONE;
      end else begin
        r1       = fx_divide(-c, b, sat);
        res.kind = qrs_pkg::KIND_ONE;
      end
    end else if (near_zero(c)) begin
      r2       = fx_divide(-b, a, sat);
      res.kind = qrs_pkg::KIND_TWO;
    end else begin
      b2  = abs_wide(b) * abs_wide(b);
      ac4 = (abs_wide(a) * abs_wide(c)) << 2;
      if ((a < 0) != (c < 0)) begin
        disc = b2 + ac4;
      end else if (b2 < ac4) begin
        res.kind = qrs_pkg::KIND_NONE;
        disc     = '1;
      end else begin
        disc = b2 - ac4;
      end
      if (disc != '1) begin
        res.kind = qrs_pkg::KIND_TWO;
        if (disc < (128'(tol_model) << qrs_pkg::FRAC_BITS)) begin
          r1 = fx_divide(-b, 2 * a, sat);
          r2 = r1;
        end else begin
          s  = floor_sqrt(disc);
          r1 = fx_divide(s - b, 2 * a, sat);
          r2 = fx_divide(-b - s, 2 * a, sat);
        end
      end
    end
    res.root1 = qrs_pkg::word_t'(r1);
    res.root2 = qrs_pkg::word_t'(r2);
    res.sat   = sat;
    return res;
  endfunction

  function automatic roots_t typed_roots(input qrs_pkg::kind_t k, input qrs_pkg::word_t r1,
                                         input qrs_pkg::word_t r2, input logic sat);
    roots_t r;
    r.kind  = k;
    r.root1 = r1;
    r.root2 = r2;
    r.sat   = sat;
    return r;
  endfunction

  // Hold the word on the inputs until the block takes it, then log the answer.
  task automatic send_coefs(input qrs_pkg::word_t a, input qrs_pkg::word_t b,
                            input qrs_pkg::word_t c, input logic has_exp, input roots_t exp);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     = 1'b1;
    in_coef_a = a;
    in_coef_b = b;
    in_coef_c = c;
    do @(posedge clk); while (busy);
    pending_roots.push_back(has_exp ? exp : solve_roots(a, b, c));
    n_words_in++;
    @(negedge clk);
  endtask

  // Drain the pipeline, then write the tolerance.
  task automatic write_tolerance(input logic [15:0] tol);
    start = 1'b0;
    wait (pending_roots.size() == 0);
    repeat (qrs_pkg::TOTAL_LAT + 4) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = tol;
    @(negedge clk);
    cfg_we    = 1'b0;
    tol_model = tol;
  endtask

  function automatic qrs_pkg::word_t near_tol_value(input logic [15:0] tol);
    qrs_pkg::word_t v;
    v = qrs_pkg::word_t'($urandom_range(0, int'(tol) + 2));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Check every strobed word against the oldest expectation.
  always @(posedge clk) begin
    roots_t exp;
    if (rst_n && out_strobe) begin
      n_words_out++;
      if (pending_roots.size() == 0) begin
        $error("result word with nothing expected");
        n_errors++;
      end else begin
        exp = pending_roots.pop_front();
        n_kind_seen[out_solution_kind]++;
        if (out_root_saturated) n_sat_seen++;
        if (out_solution_kind !== exp.kind) begin
          $error("solution_kind: expected %0d, got %0d", exp.kind, out_solution_kind);
          n_errors++;
        end
        if (out_root_first !== exp.root1) begin
          $error("root_first: expected %0d, got %0d", exp.root1, out_root_first);
          n_errors++;
        end
        if (out_root_second !== exp.root2) begin
          $error("root_second: expected %0d, got %0d", exp.root2, out_root_second);
          n_errors++;
        end
        if (out_root_saturated !== exp.sat) begin
          $error("root_saturated: expected %0d, got %0d", exp.sat, out_root_saturated);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("tb_quadratic_root_solver_unit: FAIL");
    $finish;
  end

  initial begin
    coef_row_t       rows[$];
    roots_t          none_exp;
    logic [15:0]     tols[N_PHASES];
    qrs_pkg::word_t  a;
    qrs_pkg::word_t  b;
    qrs_pkg::word_t  c;
    int              k;
    int              p;
    int              q;
    int              sel;
    none_exp    = typed_roots(qrs_pkg::KIND_NONE, 0, 0, 1'b0);
    n_errors    = 0;
    n_words_in  = 0;
    n_words_out = 0;
    n_sat_seen  = 0;
    foreach (n_kind_seen[i]) n_kind_seen[i] = 0;
    tol_model   = 16'd1;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_coef_a   = '0;
    in_coef_b   = '0;
    in_coef_c   = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed words at the reset tolerance.
    rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, typed_roots(qrs_pkg::KIND_ALL, 0, 0, 1'b0)},
      '{32'sd0, 32'sd0, 32'sh10000, 1'b1, none_exp},
      '{32'sd0, 32'sh10000, -32'sh20000, 1'b1,
        typed_roots(qrs_pkg::KIND_ONE, 32'sh20000, 0, 1'b0)},
      '{32'sh10000, 32'sh30000, 32'sd0, 1'b1,
        typed_roots(qrs_pkg::KIND_TWO, 0, -32'sh30000, 1'b0)},
      '{32'sh10000, 32'sd0, 32'sh10000, 1'b1, none_exp},
      '{32'sh10000, -32'sh20000, 32'sh10000, 1'b1,
        typed_roots(qrs_pkg::KIND_TWO, 32'sh10000, 32'sh10000, 1'b0)},
      '{32'sd1, 32'sh7fffffff, 32'sd0, 1'b1,
        typed_roots(qrs_pkg::KIND_TWO, 0, 32'sh80000000, 1'b1)},
      '{32'sd0, 32'sd1, 32'sh7fffffff, 1'b1,
        typed_roots(qrs_pkg::KIND_ONE, 32'sh80000000, 0, 1'b1)},
      '{32'sh10000, 32'sh10000, -32'sh60000, 1'b0, none_exp},
      '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0, none_exp},
      '{32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, none_exp},
      '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0, none_exp},
      '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0, none_exp},
      '{-32'sd1, 32'sh80000000, 32'sd1, 1'b0, none_exp},
      '{32'sh20000, -32'sh50000, -32'sh30000, 1'b0, none_exp},
      '{-32'sd1, -32'sd1, -32'sd1, 1'b0, none_exp}
    };
    write_tolerance(16'd1);
    foreach (rows[i]) send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].has_exp,
                                 rows[i].exp);

    // Random phases; tolerance zero opens the zero-divisor path.
    tols[0] = 16'd1;
    tols[1] = 16'd0;
    tols[2] = 16'hffff;
    tols[3] = 16'($urandom_range(2, 255));
    tols[4] = 16'($urandom_range(256, 65534));
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_tolerance(tols[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Drop the sender once per phase until the pipeline is empty.
        if (n == PHASE_ITEMS / 2) begin
          start = 1'b0;
          wait (pending_roots.size() == 0);
          @(negedge clk);
        end
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          // Build a well-formed equation from known integer roots.
          k = $urandom_range(1, 6) * ($urandom_range(0, 1) ? 1 : -1);
          p = $urandom_range(0, 60) - 30;
          q = ($urandom_range(0, 3) == 0) ? p : $urandom_range(0, 60) - 30;
          a = qrs_pkg::word_t'(k <<< 16);
          b = qrs_pkg::word_t'((-k * (p + q)) <<< 16);
          c = qrs_pkg::word_t'((k * p * q) <<< 16);
          if ($urandom_range(0, 1)) b = b + qrs_pkg::word_t'($urandom_range(0, 511)) - 256;
        end else if (sel < 6) begin
          a = qrs_pkg::word_t'($urandom);
          b = qrs_pkg::word_t'($urandom);
          c = qrs_pkg::word_t'($urandom);
        end else if (sel < 8) begin
          a = qrs_pkg::word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
          b = qrs_pkg::word_t'($urandom_range(0, 32'h3fffff)) - 32'sh200000;
          c = qrs_pkg::word_t'($urandom_range(0, 32'h3fffff)) - 32'sh200000;
        end else begin
          // Coefficients near the tolerance edge.
          a = $urandom_range(0, 1) ? near_tol_value(tol_model) : qrs_pkg::word_t'($urandom);
          b = $urandom_range(0, 1) ? near_tol_value(tol_model) : qrs_pkg::word_t'($urandom);
          c = $urandom_range(0, 1) ? near_tol_value(tol_model) : qrs_pkg::word_t'($urandom);
        end
        send_coefs(a, b, c, 1'b0, none_exp);
      end
    end
    start = 1'b0;

    wait (pending_roots.size() == 0);
    repeat (qrs_pkg::TOTAL_LAT + 10) @(negedge clk);
    $display("Covered %0d words in, %0d out, over %0d tolerance settings incl. 0 and max.",
             n_words_in, n_words_out, N_PHASES + 1);
    $display("Kinds none/one/two/all: %0d/%0d/%0d/%0d, saturated roots: %0d.",
             n_kind_seen[0], n_kind_seen[1], n_kind_seen[2], n_kind_seen[3], n_sat_seen);
    if (n_errors == 0 && pending_roots.size() == 0) begin
      $display("tb_quadratic_root_solver_unit: PASS");
    end else begin
      $display("tb_quadratic_root_solver_unit: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver_unit.sv
sim/tb_quadratic_root_solver_unit.sv
